// ----- hdl/intd_pkg.sv -----
// Package: types, offsets and defaults for the interrupt distributor register front end.
package intd_pkg;

  localparam int NumLinesDefault    = 96;
  localparam int EnableWordsDefault = 3;
  localparam int ConfigWordsDefault = 6;
  localparam int TypeValueDefault   = 2;

  localparam logic [3:0]  ACCESS_BYTES = 4'd4;

  localparam logic [11:0] OFS_CTRL     = 12'h000;
  localparam logic [11:0] OFS_TYPE     = 12'h004;
  localparam logic [11:0] WIN_EN_MASK  = 12'hF80;
  localparam logic [11:0] WIN_EN_SET   = 12'h100;
  localparam logic [11:0] WIN_EN_CLR   = 12'h180;
  localparam logic [11:0] WIN_Q_MASK   = 12'hC00;
  localparam logic [11:0] WIN_PRIO     = 12'h400;
  localparam logic [11:0] WIN_TARGET   = 12'h800;
  localparam logic [11:0] WIN_CFG_MASK = 12'hF00;
  localparam logic [11:0] WIN_CFG      = 12'hC00;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_ADDR_ERR = 1'b1;

  typedef enum logic [1:0] {
    SEL_ZERO,
    SEL_REG,
    SEL_PRIO,
    SEL_CFG
  } intd_rsel_e;

endpackage

// ----- hdl/intd_ifs.sv -----
// Interfaces: bus access request channel and response channel.
interface intd_req_if;
  logic        valid;
  logic        ready;
  logic        write_not_read;
  logic [11:0] address;
  logic [3:0]  access_size;
  logic [31:0] write_data;

  modport source (output valid, output write_not_read, output address,
                  output access_size, output write_data, input ready);
  modport sink   (input valid, input write_not_read, input address,
                  input access_size, input write_data, output ready);
  modport mon    (input valid, input ready, input write_not_read, input address,
                  input access_size, input write_data);
endinterface

interface intd_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        status;

  modport source (output valid, output read_data, output status, input ready);
  modport sink   (input valid, input read_data, input status, output ready);
  modport mon    (input valid, input ready, input read_data, input status);
endinterface

// ----- hdl/interrupt_distributor_regs_top.sv -----
// Top level: interrupt distributor register decode, storage and response register.
//
//   channel  | dir | payload                                       | transfer when
//   req_i    | in  | write_not_read, address, access_size, write_data | valid & ready
//   rsp_o    | out | read_data, status                             | valid & ready
//
// One access per cycle while req_i.ready is high; its registered response shows in the cycle after the transfer.
// Priority and configuration words sit in memories with a registered read port; a
// valid bit per row makes unwritten rows read as zero straight after reset.
// req_i.ready is low only while a response is held and rsp_o.ready is low.
// Reset is asynchronous and clears control, enables, valid bits and the response flag.
module interrupt_distributor_regs_top
  import intd_pkg::*;
#(
  parameter int NUM_LINES    = NumLinesDefault,
  parameter int ENABLE_WORDS = EnableWordsDefault,
  parameter int CONFIG_WORDS = ConfigWordsDefault,
  parameter int TYPE_VALUE   = TypeValueDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  intd_req_if.sink   req_i,
  intd_rsp_if.source rsp_o
);

  localparam int PrioRows = (NUM_LINES + 3) / 4;
  localparam int RowW     = $clog2(PrioRows);
  localparam int EnW      = (ENABLE_WORDS > 1) ? $clog2(ENABLE_WORDS) : 1;
  localparam int CfgW     = $clog2(CONFIG_WORDS);

  logic        in_fire;
  logic        wr;
  logic [11:0] addr;
  logic [31:0] wdata;
  logic        size_ok;

  logic [4:0]  en_idx;
  logic [5:0]  cfg_idx;
  logic [7:0]  prio_idx;
  logic        en_in_range, cfg_in_range, prio_in_range;
  logic [3:0]  prio_bmask;

  logic        en_we, ctl_we, prio_we, prio_re, cfg_we, cfg_re;
  intd_rsel_e  sel_d;
  logic [31:0] reg_rd_d;
  logic        err_d;

  logic [31:0] ctl_q;
  logic [31:0] en_q [ENABLE_WORDS];
  logic [31:0] prio_mem [PrioRows];
  logic [PrioRows-1:0] prio_vld_q;
  logic [31:0] cfg_mem [CONFIG_WORDS];
  logic [CONFIG_WORDS-1:0] cfg_vld_q;

  logic        out_valid_q;
  intd_rsel_e  sel_q;
  logic [31:0] reg_rd_q;
  logic        err_q;
  logic [31:0] prio_rdata_q;
  logic        prio_row_vld_q;
  logic [3:0]  prio_bmask_q;
  logic [31:0] cfg_rdata_q;
  logic        cfg_row_vld_q;
  logic [31:0] rdata;

  assign req_i.ready = !out_valid_q || rsp_o.ready;
  assign in_fire     = req_i.valid && req_i.ready;

  assign wr      = req_i.write_not_read;
  assign addr    = req_i.address;
  assign wdata   = req_i.write_data;
  assign size_ok = (req_i.access_size == ACCESS_BYTES) && (addr[1:0] == 2'b00);

  assign en_idx        = addr[6:2];
  assign cfg_idx       = addr[7:2];
  assign prio_idx      = addr[9:2];
  assign en_in_range   = {1'b0, en_idx} < 6'(ENABLE_WORDS);
  assign cfg_in_range  = {1'b0, cfg_idx} < 7'(CONFIG_WORDS);
  assign prio_in_range = {1'b0, prio_idx} < 9'(PrioRows);

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      prio_bmask[k] = {1'b0, prio_idx, 2'(k)} < 11'(NUM_LINES);
    end
  end

  always_comb begin
    en_we    = 1'b0;
    ctl_we   = 1'b0;
    prio_we  = 1'b0;
    prio_re  = 1'b0;
    cfg_we   = 1'b0;
    cfg_re   = 1'b0;
    sel_d    = SEL_ZERO;
    reg_rd_d = '0;
    err_d    = STATUS_OK;
    if (!size_ok) begin
      err_d = STATUS_ADDR_ERR;
    end else if ((addr & WIN_EN_MASK) == WIN_EN_SET || (addr & WIN_EN_MASK) == WIN_EN_CLR) begin
      if (en_in_range) begin
        if (wr) begin
          en_we = 1'b1;
        end else begin
          sel_d    = SEL_REG;
          reg_rd_d = en_q[en_idx[EnW-1:0]];
        end
      end
    end else if ((addr & WIN_Q_MASK) == WIN_PRIO) begin
      if (prio_in_range) begin
        if (wr) begin
          prio_we = 1'b1;
        end else begin
          prio_re = 1'b1;
          sel_d   = SEL_PRIO;
        end
      end
    end else if ((addr & WIN_Q_MASK) == WIN_TARGET) begin
      sel_d = SEL_ZERO;
    end else if ((addr & WIN_CFG_MASK) == WIN_CFG) begin
      if (cfg_in_range) begin
        if (wr) begin
          cfg_we = 1'b1;
        end else begin
          cfg_re = 1'b1;
          sel_d  = SEL_CFG;
        end
      end
    end else if (addr == OFS_CTRL) begin
      if (wr) begin
        ctl_we = 1'b1;
      end else begin
        sel_d    = SEL_REG;
        reg_rd_d = ctl_q;
      end
    end else if (addr == OFS_TYPE) begin
      if (wr) begin
        err_d = STATUS_ADDR_ERR;
      end else begin
        sel_d    = SEL_REG;
        reg_rd_d = 32'(TYPE_VALUE);
      end
    end else begin
      err_d = STATUS_ADDR_ERR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
      for (int i = 0; i < ENABLE_WORDS; i++) begin
        en_q[i] <= '0;
      end
      prio_vld_q <= '0;
      cfg_vld_q  <= '0;
    end else if (in_fire) begin
      if (ctl_we) begin
        ctl_q <= wdata;
      end
      if (en_we) begin
        if ((addr & WIN_EN_MASK) == WIN_EN_SET) begin
          en_q[en_idx[EnW-1:0]] <= en_q[en_idx[EnW-1:0]] | wdata;
        end else begin
          en_q[en_idx[EnW-1:0]] <= en_q[en_idx[EnW-1:0]] & ~wdata;
        end
      end
      if (prio_we) begin
        prio_vld_q[prio_idx[RowW-1:0]] <= 1'b1;
      end
      if (cfg_we) begin
        cfg_vld_q[cfg_idx[CfgW-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && prio_we) begin
      prio_mem[prio_idx[RowW-1:0]] <= wdata;
    end
    if (in_fire && prio_re) begin
      prio_rdata_q   <= prio_mem[prio_idx[RowW-1:0]];
      prio_row_vld_q <= prio_vld_q[prio_idx[RowW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && cfg_we) begin
      cfg_mem[cfg_idx[CfgW-1:0]] <= wdata;
    end
    if (in_fire && cfg_re) begin
      cfg_rdata_q   <= cfg_mem[cfg_idx[CfgW-1:0]];
      cfg_row_vld_q <= cfg_vld_q[cfg_idx[CfgW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= in_fire || (out_valid_q && !rsp_o.ready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      sel_q        <= sel_d;
      reg_rd_q     <= reg_rd_d;
      err_q        <= err_d;
      prio_bmask_q <= prio_bmask;
    end
  end

  always_comb begin
    rdata = '0;
    case (sel_q)
      SEL_REG: begin
        rdata = reg_rd_q;
      end
      SEL_PRIO: begin
        for (int k = 0; k < 4; k++) begin
          rdata[8*k +: 8] = (prio_row_vld_q && prio_bmask_q[k]) ? prio_rdata_q[8*k +: 8]
                                                                : 8'h00;
        end
      end
      SEL_CFG: begin
        rdata = cfg_row_vld_q ? cfg_rdata_q : '0;
      end
      default: begin
        rdata = '0;
      end
    endcase
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.read_data = rdata;
  assign rsp_o.status    = err_q;

endmodule

// ----- hdl/intd_chk.sv -----
// Checker: port-level properties of the register front end, bound to the top level.
module intd_chk
  import intd_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  intd_req_if.sink   req_i,
  intd_rsp_if.source rsp_o
);

  a_resp_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> rsp_o.valid)
    else $error("no response after a transfer");

  a_bad_size_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready && req_i.access_size != ACCESS_BYTES)
      |=> (rsp_o.status == STATUS_ADDR_ERR))
    else $error("bad size not flagged");

  a_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready && req_i.write_not_read) |=> (rsp_o.read_data == 32'h0))
    else $error("write returned data");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status == STATUS_ADDR_ERR) |-> (rsp_o.read_data == 32'h0))
    else $error("error with nonzero data");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rsp_o.valid |-> req_i.ready)
    else $error("request stalled with empty response stage");

endmodule

bind interrupt_distributor_regs_top intd_chk u_intd_chk (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .req_i  (req_i),
  .rsp_o  (rsp_o)
);

// ----- test/tb.sv -----
// Testbench: directed and random bus accesses to the distributor registers, checked per transfer.
module tb
  import intd_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NLines = NumLinesDefault;
  localparam int NEnable = EnableWordsDefault;
  localparam int NConfig = ConfigWordsDefault;
  localparam int NRandom = 1800;
  localparam int CycleLimit = 200000;

  typedef struct packed {
    bit          hold;
    logic        wr;
    logic [11:0] addr;
    logic [3:0]  size;
    logic [31:0] data;
  } bus_access_t;

  typedef struct packed {
    logic [31:0] rdata;
    logic        status;
  } bus_reply_t;

  logic clk;
  logic rst_n;

  intd_req_if req ();
  intd_rsp_if rsp ();

  interrupt_distributor_regs_top #(
    .NUM_LINES   (NLines),
    .ENABLE_WORDS(NEnable),
    .CONFIG_WORDS(NConfig),
    .TYPE_VALUE  (TypeValueDefault)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req),
    .rsp_o (rsp)
  );

  // register image kept alongside the block
  logic [31:0] ctrl_img = '0;
  logic [31:0] enable_img [NEnable] = '{default: '0};
  logic [7:0]  prio_img [NLines] = '{default: '0};
  logic [31:0] cfg_img [NConfig] = '{default: '0};

  bus_access_t pending_accesses[$];
  bus_reply_t  expected_replies[$];
  bus_access_t on_bus;
  bus_reply_t  oldest;
  int          n_issued = 0;
  int          n_answered = 0;
  int          n_mismatches = 0;
  int          n_cycles = 0;

  function automatic bus_reply_t predict_reply(bus_access_t a);
    bus_reply_t r;
    int idx;
    int line;
    r.rdata = '0;
    r.status = STATUS_OK;
    if (a.size != ACCESS_BYTES || a.addr[1:0] != 2'b00) begin
      r.status = STATUS_ADDR_ERR;
    end else if ((a.addr & WIN_EN_MASK) == WIN_EN_SET || (a.addr & WIN_EN_MASK) == WIN_EN_CLR) begin
      idx = int'(a.addr[6:2]);
      if (idx < NEnable) begin
        if (!a.wr) begin
          r.rdata = enable_img[idx];
        end else if ((a.addr & WIN_EN_MASK) == WIN_EN_SET) begin
          enable_img[idx] = enable_img[idx] | a.data;
        end else begin
          enable_img[idx] = enable_img[idx] & ~a.data;
        end
      end
    end else if ((a.addr & WIN_Q_MASK) == WIN_PRIO) begin
      for (int k = 0; k < 4; k++) begin
        line = int'(a.addr[9:0]) + k;
        if (line < NLines) begin
          if (a.wr) prio_img[line] = a.data[8*k +: 8];
          else r.rdata[8*k +: 8] = prio_img[line];
        end
      end
    end else if ((a.addr & WIN_Q_MASK) == WIN_TARGET) begin
      r.rdata = '0;
    end else if ((a.addr & WIN_CFG_MASK) == WIN_CFG) begin
      idx = int'(a.addr[7:2]);
      if (idx < NConfig) begin
        if (a.wr) cfg_img[idx] = a.data;
        else r.rdata = cfg_img[idx];
      end
    end else if (a.addr == OFS_CTRL) begin
      if (a.wr) ctrl_img = a.data;
      else r.rdata = ctrl_img;
    end else if (a.addr == OFS_TYPE) begin
      if (a.wr) r.status = STATUS_ADDR_ERR;
      else r.rdata = 32'(TypeValueDefault);
    end else begin
      r.status = STATUS_ADDR_ERR;
    end
    if (a.wr || r.status == STATUS_ADDR_ERR) r.rdata = '0;
    return r;
  endfunction

  task automatic report(string msg);
    n_mismatches++;
    $display("mismatch: %s", msg);
  endtask

  task automatic queue_access(logic wr, logic [11:0] addr, logic [3:0] size, logic [31:0] data,
                              bit hold = 1'b0);
    bus_access_t a;
    a.hold = hold;
    a.wr = wr;
    a.addr = addr;
    a.size = size;
    a.data = data;
    pending_accesses.push_back(a);
  endtask

  task automatic queue_random(bit hold);
    logic [11:0] addr;
    logic [31:0] data;
    int          idx;
    case ($urandom_range(0, 9))
      0: data = '0;
      1: data = '1;
      default: data = $urandom;
    endcase
    if ($urandom_range(0, 99) < 15) begin
      queue_access(1'($urandom_range(0, 1)), 12'($urandom_range(0, 4095)),
                   4'($urandom_range(0, 15)), data, hold);
    end else begin
      case ($urandom_range(0, 9))
        0: addr = OFS_CTRL;
        1: addr = OFS_TYPE;
        2, 3: begin
          idx = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31) : $urandom_range(0, NEnable);
          addr = ($urandom_range(0, 1) ? WIN_EN_SET : WIN_EN_CLR) + 12'(idx * 4);
        end
        4, 5: begin
          idx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                             : $urandom_range(0, NLines / 4);
          addr = WIN_PRIO + 12'(idx * 4);
        end
        6: addr = WIN_TARGET + 12'($urandom_range(0, 255) * 4);
        7, 8: begin
          idx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, NConfig);
          addr = WIN_CFG + 12'(idx * 4);
        end
        default: addr = 12'($urandom_range(0, 1023) * 4);
      endcase
      queue_access(1'($urandom_range(0, 1)), addr, ACCESS_BYTES, data, hold);
    end
  endtask

  // no idling at all over one stretch of the run
  function automatic bit take_gap();
    if (n_issued >= 700 && n_issued < 1100) return 1'b0;
    return $urandom_range(0, 99) < 36;
  endfunction

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // request side: predict on each transfer, then present the next access
  always @(posedge clk) begin
    if (!rst_n) begin
      req.valid <= 1'b0;
    end else begin
      if (req.valid && req.ready) begin
        expected_replies.push_back(predict_reply(on_bus));
        n_issued++;
      end
      if (!req.valid || req.ready) begin
        if (pending_accesses.size() != 0 && !take_gap() &&
            !(pending_accesses[0].hold && n_answered != n_issued)) begin
          on_bus = pending_accesses.pop_front();
          req.valid <= 1'b1;
          req.write_not_read <= on_bus.wr;
          req.address <= on_bus.addr;
          req.access_size <= on_bus.size;
          req.write_data <= on_bus.data;
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // response side
  always @(posedge clk) begin
    if (!rst_n) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        n_answered <= n_answered + 1;
        if (expected_replies.size() == 0) begin
          report("response transfer with no access outstanding");
        end else begin
          oldest = expected_replies.pop_front();
          if (rsp.read_data !== oldest.rdata)
            report($sformatf("read_data %h, expected %h", rsp.read_data, oldest.rdata));
          if (rsp.status !== oldest.status)
            report($sformatf("status %b, expected %b", rsp.status, oldest.status));
        end
      end
      rsp.ready <= !take_gap();
    end
  end

  initial begin
    rst_n = 1'b0;
    req.valid = 1'b0;
    req.write_not_read = 1'b0;
    req.address = '0;
    req.access_size = '0;
    req.write_data = '0;
    rsp.ready = 1'b0;

    queue_access(1'b0, OFS_CTRL, ACCESS_BYTES, '0);
    queue_access(1'b1, OFS_CTRL, ACCESS_BYTES, 32'hFFFF_FFFF);
    queue_access(1'b0, OFS_CTRL, ACCESS_BYTES, '0);
    queue_access(1'b0, OFS_TYPE, ACCESS_BYTES, '0);
    queue_access(1'b1, OFS_TYPE, ACCESS_BYTES, 32'h1234_5678);
    queue_access(1'b1, WIN_EN_SET + 12'h008, ACCESS_BYTES, 32'hFFFF_FFFF);
    queue_access(1'b1, WIN_EN_CLR + 12'h008, ACCESS_BYTES, 32'h0000_FFFF);
    queue_access(1'b0, WIN_EN_SET + 12'h008, ACCESS_BYTES, '0);
    queue_access(1'b1, WIN_EN_SET + 12'h00C, ACCESS_BYTES, 32'h0000_0001);
    queue_access(1'b0, WIN_EN_CLR + 12'h07C, ACCESS_BYTES, '0);
    queue_access(1'b1, WIN_PRIO, ACCESS_BYTES, 32'h0403_0201);
    queue_access(1'b0, WIN_PRIO, ACCESS_BYTES, '0);
    queue_access(1'b1, WIN_PRIO + 12'(NLines - 4), ACCESS_BYTES, 32'hFFFF_FFFF);
    queue_access(1'b0, WIN_PRIO + 12'(NLines - 4), ACCESS_BYTES, '0);
    queue_access(1'b0, WIN_PRIO + 12'h3FC, ACCESS_BYTES, '0);
    queue_access(1'b1, WIN_CFG + 12'(4 * (NConfig - 1)), ACCESS_BYTES, 32'hDEAD_BEEF);
    queue_access(1'b0, WIN_CFG + 12'(4 * (NConfig - 1)), ACCESS_BYTES, '0);
    queue_access(1'b1, WIN_CFG + 12'(4 * NConfig), ACCESS_BYTES, 32'h0000_0001);
    queue_access(1'b0, WIN_CFG + 12'h0FC, ACCESS_BYTES, '0);
    queue_access(1'b1, WIN_TARGET, ACCESS_BYTES, 32'hFFFF_FFFF);
    queue_access(1'b0, WIN_TARGET + 12'h3FC, ACCESS_BYTES, '0);
    queue_access(1'b0, OFS_CTRL + 12'h001, ACCESS_BYTES, '0);
    queue_access(1'b0, OFS_CTRL, 4'd8, '0);
    queue_access(1'b1, 12'hFFF, 4'd15, '0);
    queue_access(1'b0, 12'h008, ACCESS_BYTES, '0);
    queue_access(1'b0, 12'hD00, 4'd0, '0);

    for (int i = 0; i < NRandom; i++) queue_random(i == 250 || i == 900 || i == 1500);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_accesses.size() != 0 || req.valid || n_answered != n_issued ||
           expected_replies.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
    if (expected_replies.size() != 0) report("accesses left without a response");
    if (n_mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
